// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/fr_pkg.sv
package fr_pkg;

  localparam int SqSteps   = 27;   // root bits of the square root
  localparam int DivSteps  = 31;   // quotient bits of each divider
  localparam int NumStages = 3 + SqSteps + 2 + DivSteps + 3;

  localparam logic [15:0] OneQ15   = 16'd32768;
  localparam logic [13:0] MinIndex = 14'd4097;
  localparam logic [13:0] RstIndex = 14'd6144;
  localparam logic [30:0] OneQ30   = 31'h4000_0000;
  localparam logic [31:0] RoundQ15 = 32'd16384;

  // square root partial state
  typedef struct packed {
    logic [30:0] rem;
    logic [26:0] root;
  } sq_t;

  // divider partial state
  typedef struct packed {
    logic [28:0] rem;
    logic [30:0] q;
  } dv_t;

  // one restoring square root step, two radicand bits in
  function automatic sq_t sq_step(sq_t s, logic [1:0] b);
    logic [30:0] r;
    logic [30:0] tr;
    sq_t o;
    r  = {s.rem[28:0], b};
    tr = {2'b00, s.root, 2'b01};
    if (r >= tr) begin
      o.rem  = r - tr;
      o.root = {s.root[25:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {s.root[25:0], 1'b0};
    end
    return o;
  endfunction

  // one restoring fractional division step
  function automatic dv_t dv_step(dv_t d, logic [27:0] sum);
    logic        ge;
    logic [28:0] nr;
    dv_t o;
    ge = (d.rem >= {1'b0, sum});
    nr = ge ? (d.rem - {1'b0, sum}) : d.rem;
    o.q   = {d.q[29:0], ge};
    o.rem = {nr[27:0], 1'b0};
    return o;
  endfunction

endpackage

// File: rtl/core/fr_ifs.sv
// cosine input channel
interface fr_cos_if;
  logic        valid;
  logic        ready;
  logic [15:0] cos_incidence;
  modport source (output valid, output cos_incidence, input ready);
  modport sink (input valid, input cos_incidence, output ready);
endinterface

// reflectance result channel
interface fr_refl_if;
  logic        valid;
  logic        ready;
  logic [15:0] reflectance;
  modport source (output valid, output reflectance, input ready);
  modport sink (input valid, input reflectance, output ready);
endinterface

// refractive index write channel
interface fr_cfg_if;
  logic        valid;
  logic        ready;
  logic [13:0] refractive_index;
  modport source (output valid, output refractive_index, input ready);
  modport sink (input valid, input refractive_index, output ready);
endinterface

// File: rtl/core/fresnel_reflectance_unit.sv
// Unpolarized Fresnel reflectance of a dielectric surface.
// cos_in carries the cosine of the incidence angle (Q1.15, values above 1.0
// are clamped); refl_out returns the reflectance (Q1.15, saturated at 1.0),
// one result per item, in order.
// cfg writes the relative refractive index (Q2.12); it is always ready and
// should be written only while no item is in flight. Indices not above 1.0
// are treated as 4097.
// The pipeline has 66 register stages, and refl_out.valid is the valid bit
// of the last one.
// Stages: three setup stages, a 27-stage square root (one root bit per
// stage), two stages of setup, two 31-stage dividers running side by side
// (one quotient bit per stage) and three stages of squaring, product and
// rounding.
// Throughput is one item per cycle while refl_out does not stall.
// When refl_out stalls the whole pipeline holds and cos_in.ready drops;
// nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline and sets the index to 1.5.
`include "assert_macros.svh"

module fresnel_reflectance_unit (
  input  logic              clk,
  input  logic              rst,
  fr_cos_if.sink            cos_in,
  fr_refl_if.source         refl_out,
  fr_cfg_if.sink            cfg
);

  localparam int Last = fr_pkg::NumStages - 1;

  logic [fr_pkg::NumStages-1:0] v;
  logic                         en;
  logic [13:0]                  idx;

  // stage A..C
  logic [15:0] c_a;
  logic [13:0] n_a;
  logic [15:0] c_b;
  logic [30:0] c2_b;
  logic [27:0] nn_b;
  logic [34:0] a_w;
  logic [30:0] s2_w;

  // square root pipeline
  fr_pkg::sq_t sqs [0:fr_pkg::SqSteps];
  logic [53:0] sx  [0:fr_pkg::SqSteps];
  logic [24:0] cqp [0:fr_pkg::SqSteps];
  logic [24:0] sp  [0:fr_pkg::SqSteps];

  // stage D, E
  logic [26:0] g_w;
  logic [51:0] cg_prod;
  logic [27:0] d1_d;
  logic [27:0] sum1_d;
  logic [26:0] cg_d;
  logic [24:0] s_d;

  // divider pipelines
  fr_pkg::dv_t dv1 [0:fr_pkg::DivSteps];
  fr_pkg::dv_t dv2 [0:fr_pkg::DivSteps];
  logic [27:0] sm1 [0:fr_pkg::DivSteps];
  logic [27:0] sm2 [0:fr_pkg::DivSteps];
  logic        z1  [0:fr_pkg::DivSteps];
  logic        z2  [0:fr_pkg::DivSteps];
  logic [27:0] d2_w;
  logic [27:0] sum2_w;

  // stage F..H
  logic [30:0] t1_w;
  logic [30:0] t2_w;
  logic [61:0] t1sq;
  logic [61:0] t2sq;
  logic [30:0] t1s_f;
  logic [30:0] t2s_f;
  logic [62:0] r_prod;
  logic [30:0] r_g;
  logic [31:0] rr_w;
  logic [16:0] q17_w;
  logic [15:0] res;

  // global advance: everything moves unless the result is stuck
  assign en            = !v[Last] || refl_out.ready;
  assign cos_in.ready  = en;
  assign cfg.ready     = 1'b1;
  assign refl_out.valid       = v[Last];
  assign refl_out.reflectance = res;

  // index register and valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= fr_pkg::RstIndex;
      v   <= '0;
    end else begin
      if (cfg.valid) begin
        idx <= cfg.refractive_index;
      end
      if (en) begin
        v <= {v[Last-1:0], cos_in.valid};
      end
    end
  end

  // stage A: clamp inputs
  always_ff @(posedge clk) begin
    if (en) begin
      c_a <= (cos_in.cos_incidence > fr_pkg::OneQ15) ? fr_pkg::OneQ15
                                                     : cos_in.cos_incidence;
      n_a <= (idx < fr_pkg::MinIndex) ? fr_pkg::MinIndex : idx;
    end
  end

  // stage B: squares
  always_ff @(posedge clk) begin
    if (en) begin
      c_b  <= c_a;
      c2_b <= 31'(c_a) * 31'(c_a);
      nn_b <= 28'(n_a) * 28'(n_a);
    end
  end

  // stage C: radicand, sin squared, scaled cosine
  assign a_w  = 35'(c2_b) + {1'b0, nn_b, 6'b0} - 35'(fr_pkg::OneQ30);
  assign s2_w = fr_pkg::OneQ30 - c2_b;

  always_ff @(posedge clk) begin
    if (en) begin
      sx[0]  <= {1'b0, a_w, 18'b0};
      sqs[0] <= '0;
      cqp[0] <= {c_b, 9'b0};
      sp[0]  <= s2_w[30:6];
    end
  end

  // square root, one root bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < fr_pkg::SqSteps; k++) begin
        sqs[k+1] <= fr_pkg::sq_step(sqs[k], sx[k][53:52]);
        sx[k+1]  <= {sx[k][51:0], 2'b00};
        cqp[k+1] <= cqp[k];
        sp[k+1]  <= sp[k];
      end
    end
  end

  // stage D: first ratio operands and c*g
  assign g_w     = sqs[fr_pkg::SqSteps].root;
  assign cg_prod = 52'(cqp[fr_pkg::SqSteps]) * 52'(g_w);

  always_ff @(posedge clk) begin
    if (en) begin
      d1_d   <= (g_w >= 27'(cqp[fr_pkg::SqSteps]))
                ? 28'(g_w) - 28'(cqp[fr_pkg::SqSteps])
                : 28'(cqp[fr_pkg::SqSteps]) - 28'(g_w);
      sum1_d <= 28'(g_w) + 28'(cqp[fr_pkg::SqSteps]);
      cg_d   <= cg_prod[50:24];
      s_d    <= sp[fr_pkg::SqSteps];
    end
  end

  // stage E: second ratio operands, load dividers
  assign d2_w   = (cg_d >= 27'(s_d)) ? 28'(cg_d) - 28'(s_d) : 28'(s_d) - 28'(cg_d);
  assign sum2_w = 28'(cg_d) + 28'(s_d);

  always_ff @(posedge clk) begin
    if (en) begin
      dv1[0] <= '{rem: {1'b0, d1_d}, q: '0};
      dv2[0] <= '{rem: {1'b0, d2_w}, q: '0};
      sm1[0] <= sum1_d;
      sm2[0] <= sum2_w;
      z1[0]  <= (sum1_d == '0);
      z2[0]  <= (sum2_w == '0);
    end
  end

  // two dividers, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < fr_pkg::DivSteps; k++) begin
        dv1[k+1] <= fr_pkg::dv_step(dv1[k], sm1[k]);
        dv2[k+1] <= fr_pkg::dv_step(dv2[k], sm2[k]);
        sm1[k+1] <= sm1[k];
        sm2[k+1] <= sm2[k];
        z1[k+1]  <= z1[k];
        z2[k+1]  <= z2[k];
      end
    end
  end

  // stage F: square the ratios
  assign t1_w = z1[fr_pkg::DivSteps] ? fr_pkg::OneQ30 : dv1[fr_pkg::DivSteps].q;
  assign t2_w = z2[fr_pkg::DivSteps] ? fr_pkg::OneQ30 : dv2[fr_pkg::DivSteps].q;
  assign t1sq = 62'(t1_w) * 62'(t1_w);
  assign t2sq = 62'(t2_w) * 62'(t2_w);

  always_ff @(posedge clk) begin
    if (en) begin
      t1s_f <= t1sq[60:30];
      t2s_f <= t2sq[60:30];
    end
  end

  // stage G: average of the polarization terms
  assign r_prod = 63'(t1s_f) * 63'({1'b0, fr_pkg::OneQ30} + 32'(t2s_f));

  always_ff @(posedge clk) begin
    if (en) begin
      r_g <= r_prod[61:31];
    end
  end

  // stage H: round to Q1.15 and saturate
  assign rr_w  = 32'(r_g) + fr_pkg::RoundQ15;
  assign q17_w = rr_w[31:15];

  always_ff @(posedge clk) begin
    if (en) begin
      res <= (q17_w > 17'(fr_pkg::OneQ15)) ? fr_pkg::OneQ15 : q17_w[15:0];
    end
  end

  // checks
  `ASSERT_IMPLIES(a_out_range, clk, rst, refl_out.valid,
                  refl_out.reflectance <= fr_pkg::OneQ15)
  `ASSERT_IMPLIES(a_stall_only, clk, rst, !cos_in.ready,
                  refl_out.valid && !refl_out.ready)
  `ASSERT_IMPLIES(a_ratio_range, clk, rst, v[Last-2],
                  t1s_f <= fr_pkg::OneQ30 && t2s_f <= fr_pkg::OneQ30)
  `ASSERT_NEXT(a_hold_on_stall, clk, rst, !en, v == $past(v))

endmodule

// File: verif/fresnel_reflectance_unit_test.sv
`timescale 1ns / 100ps

module fresnel_reflectance_unit_test;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fr_cos_if  cos_ch ();
  fr_refl_if refl_ch ();
  fr_cfg_if  cfg_ch ();

  fresnel_reflectance_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .cos_in   (cos_ch.sink),
    .refl_out (refl_ch.source),
    .cfg      (cfg_ch.sink)
  );

  always #6 clk = ~clk;

  // working copy of the index register
  logic [13:0] index_reg;

  logic [15:0] cos_pending[$];
  logic [15:0] refl_expected[$];
  int          fail_count = 0;

  // sender burst / gap control
  int burst_left = 0;
  int gap_left = 0;
  // receiver stall pattern
  int stall_phase = 0;
  int stall_mode = 0;

  // floor square root, bit by bit
  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // squared |x-y|/(x+y) in Q.30
  function automatic logic [63:0] sq_ratio(logic [63:0] x, logic [63:0] y);
    logic [63:0] diff;
    logic [63:0] sum;
    logic [63:0] t;
    diff = (x >= y) ? x - y : y - x;
    sum = x + y;
    if (sum == 0) return 64'd1 << 30;
    t = (diff << 30) / sum;
    return (t * t) >> 30;
  endfunction

  // expected reflectance for one cosine under the current index
  function automatic logic [15:0] fresnel_of(logic [15:0] cos_raw, logic [13:0] idx);
    logic [63:0] c, n, c2, s2, a, g, cq, cg, s, t1s, t2s, r, res;
    c = 64'(cos_raw);
    n = 64'(idx);
    if (c > 32768) c = 32768;
    if (n < 4097) n = 4097;
    c2 = c * c;
    s2 = (64'd1 << 30) - c2;
    a = c2 + ((n * n) << 6) - (64'd1 << 30);
    g = isqrt64(a << 18);
    cq = c << 9;
    t1s = sq_ratio(g, cq);
    cg = (cq * g) >> 24;
    s = s2 >> 6;
    t2s = sq_ratio(cg, s);
    r = (t1s * ((64'd1 << 30) + t2s)) >> 31;
    res = (r + (64'd1 << 14)) >> 15;
    if (res > 32768) res = 32768;
    return res[15:0];
  endfunction

  // driver: pops pending items in bursts
  always @(posedge clk) begin
    if (rst) begin
      cos_ch.valid <= 1'b0;
      cos_ch.cos_incidence <= 16'd0;
    end else begin
      if (cos_ch.valid && cos_ch.ready) begin
        refl_expected.push_back(fresnel_of(cos_ch.cos_incidence, index_reg));
      end
      if (!cos_ch.valid || cos_ch.ready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          cos_ch.valid <= 1'b0;
        end else if (cos_pending.size() > 0) begin
          cos_ch.valid <= 1'b1;
          cos_ch.cos_incidence <= cos_pending.pop_front();
          if (burst_left > 0) begin
            burst_left = burst_left - 1;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          cos_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      refl_ch.ready <= 1'b0;
    end else begin
      stall_phase = stall_phase + 1;
      if (stall_phase >= 200) begin
        stall_phase = 0;
        stall_mode = $urandom_range(0, 3);
      end
      case (stall_mode)
        0: refl_ch.ready <= 1'b1;
        1: refl_ch.ready <= (stall_phase % 5) != 0;
        2: refl_ch.ready <= ($urandom_range(0, 1) == 1);
        default: refl_ch.ready <= (stall_phase % 16) < 4;
      endcase
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst && refl_ch.valid && refl_ch.ready) begin
      if (refl_expected.size() == 0) begin
        $display("%0t: unexpected reflectance %0d", $time, refl_ch.reflectance);
        fail_count = fail_count + 1;
      end else begin
        want = refl_expected.pop_front();
        if (refl_ch.reflectance !== want) begin
          $display("%0t: reflectance expected %0d actual %0d",
                   $time, want, refl_ch.reflectance);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // index write, only while idle
  task automatic write_index(logic [13:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.refractive_index <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    index_reg = value;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (cos_pending.size() > 0 || cos_ch.valid || refl_expected.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_cos();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'($urandom_range(32768, 65535));
    if (k == 1) return 16'($urandom_range(0, 64));
    if (k == 2) return 16'($urandom_range(32700, 32768));
    return 16'($urandom_range(0, 32768));
  endfunction

  initial begin
    logic [13:0] phase_index[6];
    cos_ch.valid = 1'b0;
    cos_ch.cos_incidence = 16'd0;
    refl_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.refractive_index = 14'd0;
    index_reg = fr_pkg::RstIndex;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: default index, extremes of the cosine
    cos_pending.push_back(16'd0);
    cos_pending.push_back(16'd1);
    cos_pending.push_back(16'd32767);
    cos_pending.push_back(16'd32768);
    cos_pending.push_back(16'd32769);
    cos_pending.push_back(16'hFFFF);
    cos_pending.push_back(16'h5555);
    cos_pending.push_back(16'hAAAA);
    cos_pending.push_back(16'd16384);
    wait_drained();
    // index not above one is clamped
    write_index(14'd0);
    cos_pending.push_back(16'd0);
    cos_pending.push_back(16'd32768);
    cos_pending.push_back(16'd12345);
    wait_drained();
    write_index(14'd4096);
    cos_pending.push_back(16'd100);
    cos_pending.push_back(16'd32768);
    wait_drained();
    // largest index, result near one at grazing
    write_index(14'h3FFF);
    cos_pending.push_back(16'd0);
    cos_pending.push_back(16'd1);
    cos_pending.push_back(16'd32768);
    cos_pending.push_back(16'hFFFF);
    wait_drained();

    // random phases across index settings
    phase_index[0] = 14'd4097;
    phase_index[1] = 14'h3FFF;
    phase_index[2] = fr_pkg::RstIndex;
    phase_index[3] = 14'h2AAA;
    phase_index[4] = 14'h1555;
    phase_index[5] = 14'd0;
    for (int p = 0; p < 10; p++) begin
      if (p < 6) write_index(phase_index[p]);
      else write_index(14'($urandom_range(0, 16383)));
      for (int i = 0; i < 143; i++) cos_pending.push_back(rand_cos());
      wait_drained();
    end
    if (fail_count == 0) begin
      $display("fresnel_reflectance_unit_test passed");
    end else begin
      $display("fresnel_reflectance_unit_test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("fresnel_reflectance_unit_test failed");
    $finish;
  end

endmodule
